### hw/rtl/gfbp_pkg.sv
// Package for the GIF frame boundary parser: types, codes and constants.
`timescale 1ns / 1ps

package gfbp_pkg;

   localparam int OFFSET_WIDTH_DEFAULT = 32;
   localparam int PTS_WIDTH_DEFAULT    = 40;

   localparam int OFF_FIELD_WIDTH = 32;
   localparam int PTS_FIELD_WIDTH = 40;
   localparam int DUR_WIDTH       = 16;
   localparam int CFG_WIDTH       = 13;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int SKIP_WIDTH      = 10;
   localparam int FIELD_WIDTH     = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELAY_FLOOR    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELAY_FALLBACK = 2'd1;

   localparam logic [CFG_WIDTH-1:0] DELAY_FLOOR_RESET    = 13'd2;
   localparam logic [CFG_WIDTH-1:0] DELAY_FALLBACK_RESET = 13'd10;

   localparam logic [2:0] STATUS_FRAME     = 3'd0;
   localparam logic [2:0] STATUS_END       = 3'd1;
   localparam logic [2:0] STATUS_BAD_LABEL = 3'd2;
   localparam logic [2:0] STATUS_SHORT_GCE = 3'd3;
   localparam logic [2:0] STATUS_ZERO_LZW  = 3'd4;
   localparam logic [2:0] STATUS_BAD_SIG   = 3'd5;
   localparam logic [2:0] STATUS_TRUNC     = 3'd6;

   localparam logic [7:0] LABEL_TRAILER   = 8'h3b;
   localparam logic [7:0] LABEL_EXTENSION = 8'h21;
   localparam logic [7:0] LABEL_IMAGE     = 8'h2c;
   localparam logic [7:0] LABEL_GCE       = 8'hf9;
   localparam logic [7:0] FLAG_TABLE      = 8'h80;
   localparam logic [7:0] MASK_TABLE_SIZE = 8'h07;

   localparam logic [FIELD_WIDTH-1:0] SIG_LEN      = 4'd6;
   localparam logic [FIELD_WIDTH-1:0] SCREEN_FLAGS = 4'd4;
   localparam logic [FIELD_WIDTH-1:0] DESC_FLAGS   = 4'd8;
   localparam logic [7:0]             GCE_MIN_SIZE = 8'd4;
   localparam logic [7:0]             GCE_FIELDS   = 8'd3;
   localparam logic [SKIP_WIDTH-1:0]  SCREEN_TAIL  = 10'd2;

   typedef enum logic [3:0] {
      PS_SIG,
      PS_SCREEN,
      PS_SKIP_HDR,
      PS_LABEL,
      PS_EXT_LABEL,
      PS_GCE_SIZE,
      PS_GCE_BODY,
      PS_SKIP_EXT,
      PS_EXT_SUB,
      PS_IMG_DESC,
      PS_SKIP_LCT,
      PS_LZW,
      PS_IMG_SUB,
      PS_SKIP_IMG,
      PS_IDLE
   } parse_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic [2:0]                 status;
      logic                       keyframe;
      logic [OFF_FIELD_WIDTH-1:0] frame_offset;
      logic [OFF_FIELD_WIDTH-1:0] frame_length;
      logic [PTS_FIELD_WIDTH-1:0] pts;
      logic [DUR_WIDTH-1:0]       duration;
   } rsp_type;

   function automatic logic [7:0] sig87_byte(input logic [FIELD_WIDTH-1:0] idx);
      logic [7:0] v;
      case (idx)
         4'd0: v = 8'h47;
         4'd1: v = 8'h49;
         4'd2: v = 8'h46;
         4'd3: v = 8'h38;
         4'd4: v = 8'h37;
         4'd5: v = 8'h61;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] sig89_byte(input logic [FIELD_WIDTH-1:0] idx);
      logic [7:0] v;
      case (idx)
         4'd0: v = 8'h47;
         4'd1: v = 8'h49;
         4'd2: v = 8'h46;
         4'd3: v = 8'h38;
         4'd4: v = 8'h39;
         4'd5: v = 8'h61;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   // color table bytes: 3 * 2^(n+1)
   function automatic logic [SKIP_WIDTH-1:0] table_size(input logic [7:0] flag_bits);
      logic [2:0] n;
      n = flag_bits[2:0] & MASK_TABLE_SIZE[2:0];
      return SKIP_WIDTH'(6) << n;
   endfunction

endpackage

### hw/rtl/gif_frame_boundary_parser_core.sv
// GIF frame boundary parser: byte-wide block walker that reports frame packets.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_data: data_byte, start_of_file, end_of_data
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_data: status, keyframe, offset, length, pts, dur
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data (13 bits)
//
// One request per cycle sustained while rsp_stall does not hold the response register; a request
// passes the input register, then the combinational parse step, into the response register.
// The parse step is one state update and one counter compare per byte.
// Synchronous active-high reset: parser in signature state, delay floor 2, fallback 10.
// rsp_stall holds the response register; the input register still takes one more request.
`timescale 1ns / 1ps

module gif_frame_boundary_parser_core #(
   parameter int OFFSET_WIDTH = gfbp_pkg::OFFSET_WIDTH_DEFAULT,
   parameter int PTS_WIDTH    = gfbp_pkg::PTS_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  gfbp_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output gfbp_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [gfbp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [gfbp_pkg::CFG_WIDTH-1:0]         csr_data
);
   import gfbp_pkg::*;

   localparam int OffCapW = (OFFSET_WIDTH > OFF_FIELD_WIDTH) ? OFFSET_WIDTH : OFF_FIELD_WIDTH;
   localparam int PtsCapW = (PTS_WIDTH > PTS_FIELD_WIDTH) ? PTS_WIDTH : PTS_FIELD_WIDTH;

   logic                     in_valid_ff, in_valid_in;
   req_type                  in_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff;
   logic                     advance;

   logic [CFG_WIDTH-1:0]     delay_floor_ff, delay_fallback_ff;

   parse_state_type          state_ff, state_in;
   logic [SKIP_WIDTH-1:0]    skip_ff, skip_in;
   logic [OFFSET_WIDTH-1:0]  byte_offset_ff, byte_offset_in;
   logic [OFFSET_WIDTH-1:0]  packet_start_ff, packet_start_in;
   logic [PTS_WIDTH-1:0]     running_pts_ff, running_pts_in;
   logic [DUR_WIDTH-1:0]     delay_ff, delay_in;
   logic                     header_seen_ff, header_seen_in;
   logic [1:0]               sig_match_ff, sig_match_in;
   logic [FIELD_WIDTH-1:0]   field_ff, field_in;
   logic [7:0]               block_size_ff, block_size_in;

   logic                     res_valid;
   rsp_type                  res;
   logic [7:0]               b;
   logic [1:0]               m;
   logic [DUR_WIDTH-1:0]     gce_delay;
   logic [OFFSET_WIDTH-1:0]  len;
   logic [OffCapW-1:0]       off_ext, len_ext;
   logic [PtsCapW-1:0]       pts_ext;
   logic [PTS_WIDTH:0]       pts_sum;

   // handshake
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = res_valid;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_floor_ff    <= DELAY_FLOOR_RESET;
         delay_fallback_ff <= DELAY_FALLBACK_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DELAY_FLOOR:    delay_floor_ff    <= csr_data;
            CSR_DELAY_FALLBACK: delay_fallback_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= PS_SIG;
         skip_ff         <= '0;
         byte_offset_ff  <= '0;
         packet_start_ff <= '0;
         running_pts_ff  <= '0;
         delay_ff        <= DUR_WIDTH'(DELAY_FALLBACK_RESET);
         header_seen_ff  <= 1'b0;
         sig_match_ff    <= 2'b11;
         field_ff        <= '0;
         block_size_ff   <= '0;
      end else begin
         state_ff        <= state_in;
         skip_ff         <= skip_in;
         byte_offset_ff  <= byte_offset_in;
         packet_start_ff <= packet_start_in;
         running_pts_ff  <= running_pts_in;
         delay_ff        <= delay_in;
         header_seen_ff  <= header_seen_in;
         sig_match_ff    <= sig_match_in;
         field_ff        <= field_in;
         block_size_ff   <= block_size_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      skip_in         = skip_ff;
      byte_offset_in  = byte_offset_ff;
      packet_start_in = packet_start_ff;
      running_pts_in  = running_pts_ff;
      delay_in        = delay_ff;
      header_seen_in  = header_seen_ff;
      sig_match_in    = sig_match_ff;
      field_in        = field_ff;
      block_size_in   = block_size_ff;
      res_valid       = 1'b0;
      res             = '0;
      b               = in_ff.data_byte;
      m               = 2'b00;
      gce_delay       = {b, block_size_ff};
      len             = '0;
      off_ext         = '0;
      len_ext         = '0;
      pts_ext         = '0;
      pts_sum         = '0;

      if (advance) begin
         if (in_ff.start_of_file) begin
            state_in        = PS_SIG;
            skip_in         = '0;
            byte_offset_in  = '0;
            packet_start_in = '0;
            running_pts_in  = '0;
            delay_in        = DUR_WIDTH'(delay_fallback_ff);
            header_seen_in  = 1'b0;
            sig_match_in    = 2'b11;
            field_in        = '0;
            block_size_in   = '0;
         end

         if (in_ff.end_of_data) begin
            if (state_in != PS_IDLE) begin
               res_valid = 1'b1;
               if (state_in == PS_LABEL || (state_in == PS_SIG && field_in == '0)) begin
                  res.status = STATUS_END;
               end else begin
                  res.status = STATUS_TRUNC;
               end
               state_in = PS_IDLE;
            end
         end else if (state_in != PS_IDLE) begin
            if (byte_offset_in != '1) begin
               byte_offset_in = byte_offset_in + OFFSET_WIDTH'(1);
            end
            case (state_in)
               PS_SIG: begin
                  if (field_in < SIG_LEN) begin
                     m[0] = sig_match_in[0] && (b == sig87_byte(field_in));
                     m[1] = sig_match_in[1] && (b == sig89_byte(field_in));
                  end
                  sig_match_in = m;
                  if (m == 2'b00) begin
                     res_valid  = 1'b1;
                     res.status = STATUS_BAD_SIG;
                     state_in   = PS_IDLE;
                  end else if (field_in >= SIG_LEN - FIELD_WIDTH'(1)) begin
                     field_in = '0;
                     state_in = PS_SCREEN;
                  end else begin
                     field_in = field_in + FIELD_WIDTH'(1);
                  end
               end
               PS_SCREEN: begin
                  if (field_in < SCREEN_FLAGS) begin
                     field_in = field_in + FIELD_WIDTH'(1);
                  end else begin
                     skip_in  = SCREEN_TAIL +
                                (((b & FLAG_TABLE) != '0) ? table_size(b) : '0);
                     state_in = PS_SKIP_HDR;
                  end
               end
               PS_SKIP_HDR: begin
                  skip_in = skip_in - SKIP_WIDTH'(1);
                  if (skip_in == '0) begin
                     state_in = PS_LABEL;
                  end
               end
               PS_LABEL: begin
                  if (b == LABEL_TRAILER) begin
                     res_valid  = 1'b1;
                     res.status = STATUS_END;
                     state_in   = PS_IDLE;
                  end else if (b == LABEL_EXTENSION) begin
                     state_in = PS_EXT_LABEL;
                  end else if (b == LABEL_IMAGE) begin
                     field_in = '0;
                     state_in = PS_IMG_DESC;
                  end else begin
                     res_valid  = 1'b1;
                     res.status = STATUS_BAD_LABEL;
                     state_in   = PS_IDLE;
                  end
               end
               PS_EXT_LABEL: begin
                  state_in = (b == LABEL_GCE) ? PS_GCE_SIZE : PS_EXT_SUB;
               end
               PS_GCE_SIZE: begin
                  if (b < GCE_MIN_SIZE) begin
                     res_valid  = 1'b1;
                     res.status = STATUS_SHORT_GCE;
                     state_in   = PS_IDLE;
                  end else begin
                     skip_in  = SKIP_WIDTH'(b - GCE_FIELDS);
                     field_in = '0;
                     state_in = PS_GCE_BODY;
                  end
               end
               PS_GCE_BODY: begin
                  if (field_in == FIELD_WIDTH'(0)) begin
                     field_in = FIELD_WIDTH'(1);
                  end else if (field_in == FIELD_WIDTH'(1)) begin
                     block_size_in = b;
                     field_in      = FIELD_WIDTH'(2);
                  end else begin
                     if (gce_delay < DUR_WIDTH'(delay_floor_ff)) begin
                        delay_in = DUR_WIDTH'(delay_fallback_ff);
                     end else begin
                        delay_in = gce_delay;
                     end
                     state_in = PS_SKIP_EXT;
                  end
               end
               PS_SKIP_EXT: begin
                  skip_in = skip_in - SKIP_WIDTH'(1);
                  if (skip_in == '0) begin
                     state_in = PS_EXT_SUB;
                  end
               end
               PS_EXT_SUB: begin
                  if (b == '0) begin
                     state_in = PS_LABEL;
                  end else begin
                     skip_in  = SKIP_WIDTH'(b);
                     state_in = PS_SKIP_EXT;
                  end
               end
               PS_IMG_DESC: begin
                  if (field_in < DESC_FLAGS) begin
                     field_in = field_in + FIELD_WIDTH'(1);
                  end else if ((b & FLAG_TABLE) != '0) begin
                     skip_in  = table_size(b);
                     state_in = PS_SKIP_LCT;
                  end else begin
                     state_in = PS_LZW;
                  end
               end
               PS_SKIP_LCT: begin
                  skip_in = skip_in - SKIP_WIDTH'(1);
                  if (skip_in == '0) begin
                     state_in = PS_LZW;
                  end
               end
               PS_LZW: begin
                  if (b == '0) begin
                     res_valid  = 1'b1;
                     res.status = STATUS_ZERO_LZW;
                     state_in   = PS_IDLE;
                  end else begin
                     state_in = PS_IMG_SUB;
                  end
               end
               PS_IMG_SUB: begin
                  if (b != '0) begin
                     skip_in  = SKIP_WIDTH'(b);
                     state_in = PS_SKIP_IMG;
                  end else begin
                     len     = byte_offset_in - packet_start_in;
                     off_ext = OffCapW'(packet_start_in);
                     len_ext = OffCapW'(len);
                     pts_ext = PtsCapW'(running_pts_in);
                     res_valid        = 1'b1;
                     res.status       = STATUS_FRAME;
                     res.keyframe     = !header_seen_in;
                     res.frame_offset = (off_ext > OffCapW'({OFF_FIELD_WIDTH{1'b1}})) ?
                                        '1 : off_ext[OFF_FIELD_WIDTH-1:0];
                     res.frame_length = (len_ext > OffCapW'({OFF_FIELD_WIDTH{1'b1}})) ?
                                        '1 : len_ext[OFF_FIELD_WIDTH-1:0];
                     res.pts          = (pts_ext > PtsCapW'({PTS_FIELD_WIDTH{1'b1}})) ?
                                        '1 : pts_ext[PTS_FIELD_WIDTH-1:0];
                     res.duration     = delay_in;
                     pts_sum = {1'b0, running_pts_in} + (PTS_WIDTH + 1)'(delay_in);
                     running_pts_in  = pts_sum[PTS_WIDTH] ? '1 : pts_sum[PTS_WIDTH-1:0];
                     delay_in        = DUR_WIDTH'(delay_fallback_ff);
                     header_seen_in  = 1'b1;
                     packet_start_in = byte_offset_in;
                     state_in        = PS_LABEL;
                  end
               end
               PS_SKIP_IMG: begin
                  skip_in = skip_in - SKIP_WIDTH'(1);
                  if (skip_in == '0) begin
                     state_in = PS_IMG_SUB;
                  end
               end
               default: begin
                  state_in = PS_IDLE;
               end
            endcase
         end
      end
   end

   // checks
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != STATUS_FRAME |->
         !rsp_ff.keyframe && rsp_ff.frame_offset == '0 && rsp_ff.frame_length == '0 &&
         rsp_ff.pts == '0 && rsp_ff.duration == '0)
      else $error("non-frame response carries frame fields");

   assert property (@(posedge clock) disable iff (reset)
      advance && res_valid && res.status != STATUS_FRAME |=> state_ff == PS_IDLE)
      else $error("parser not idle after a status response");

   assert property (@(posedge clock) disable iff (reset)
      advance && res_valid && res.status == STATUS_FRAME |=> header_seen_ff)
      else $error("header flag not set after frame");

   assert property (@(posedge clock) disable iff (reset)
      advance && !in_ff.start_of_file |=> byte_offset_ff >= $past(byte_offset_ff))
      else $error("byte offset moved backward within a file");

endmodule

### bench/tb_gif_frame_boundary_parser_core.sv
// Testbench for the GIF frame boundary parser: directed and random GIF byte streams.
`timescale 1ns / 1ps

module tb_gif_frame_boundary_parser_core;
   import gfbp_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 4;
   localparam int QUIET_LIMIT   = 1000;
   localparam int RANDOM_ITEMS  = 1600;

   localparam logic [47:0] SIG87 = 48'h474946383761;
   localparam logic [47:0] SIG89 = 48'h474946383961;
   localparam logic [OFF_FIELD_WIDTH-1:0] OFFSET_MAX = {OFF_FIELD_WIDTH{1'b1}};
   localparam logic [PTS_FIELD_WIDTH-1:0] PTS_MAX    = {PTS_FIELD_WIDTH{1'b1}};

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_type                    req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CFG_WIDTH-1:0]       csr_data  = '0;

   // parser state mirror
   logic [CFG_WIDTH-1:0]       delay_floor_reg    = DELAY_FLOOR_RESET;
   logic [CFG_WIDTH-1:0]       delay_fallback_reg = DELAY_FALLBACK_RESET;
   parse_state_type            gif_state;
   logic [SKIP_WIDTH-1:0]      skip_left;
   logic [OFF_FIELD_WIDTH-1:0] byte_pos;
   logic [OFF_FIELD_WIDTH-1:0] packet_base;
   logic [PTS_FIELD_WIDTH-1:0] pts_total;
   logic [DUR_WIDTH-1:0]       frame_delay;
   logic                       frame_seen;
   logic [1:0]                 sig_alive;
   logic [FIELD_WIDTH-1:0]     field_pos;
   logic [7:0]                 delay_low;

   rsp_type parser_reports[$];
   req_type file_bytes[$];
   int      error_count  = 0;
   int      parsed_count = 0;
   int      quiet_cycles = 0;
   bit      steady       = 1'b0;

   gif_frame_boundary_parser_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 38);
   end

   function automatic void restart_file();
      gif_state   = PS_SIG;
      skip_left   = '0;
      byte_pos    = '0;
      packet_base = '0;
      pts_total   = '0;
      frame_delay = DUR_WIDTH'(delay_fallback_reg);
      frame_seen  = 1'b0;
      sig_alive   = 2'b11;
      field_pos   = '0;
      delay_low   = '0;
   endfunction

   function automatic logic [SKIP_WIDTH-1:0] color_table_bytes(input logic [7:0] flags);
      return SKIP_WIDTH'(3 << (int'(flags[2:0]) + 1));
   endfunction

   function automatic bit abort_file(input logic [2:0] code, inout rsp_type rep);
      rep.status = code;
      gif_state  = PS_IDLE;
      return 1'b1;
   endfunction

   function automatic bit parse_gif_byte(input req_type r, output rsp_type rep);
      logic [7:0]           b;
      logic [1:0]           alive;
      logic [DUR_WIDTH-1:0] delay;
      b   = r.data_byte;
      rep = '0;
      if (r.start_of_file) restart_file();
      if (r.end_of_data) begin
         if (gif_state == PS_IDLE) return 1'b0;
         if (gif_state == PS_LABEL || (gif_state == PS_SIG && field_pos == 0))
            return abort_file(STATUS_END, rep);
         return abort_file(STATUS_TRUNC, rep);
      end
      if (gif_state == PS_IDLE) return 1'b0;
      if (byte_pos != OFFSET_MAX) byte_pos++;
      case (gif_state)
         PS_SIG: begin
            alive = 2'b00;
            if (field_pos < SIG_LEN) begin
               if (sig_alive[0] && b == SIG87[47 - 8*int'(field_pos) -: 8]) alive[0] = 1'b1;
               if (sig_alive[1] && b == SIG89[47 - 8*int'(field_pos) -: 8]) alive[1] = 1'b1;
            end
            sig_alive = alive;
            if (alive == 2'b00) return abort_file(STATUS_BAD_SIG, rep);
            if (field_pos >= SIG_LEN - 1) begin
               field_pos = '0;
               gif_state = PS_SCREEN;
            end else begin
               field_pos++;
            end
         end
         PS_SCREEN: begin
            if (field_pos < SCREEN_FLAGS) begin
               field_pos++;
            end else begin
               skip_left = SCREEN_TAIL + (b[7] ? color_table_bytes(b) : '0);
               gif_state = PS_SKIP_HDR;
            end
         end
         PS_SKIP_HDR: begin
            skip_left--;
            if (skip_left == 0) gif_state = PS_LABEL;
         end
         PS_LABEL: begin
            if (b == LABEL_TRAILER) return abort_file(STATUS_END, rep);
            if (b == LABEL_EXTENSION) begin
               gif_state = PS_EXT_LABEL;
            end else if (b == LABEL_IMAGE) begin
               field_pos = '0;
               gif_state = PS_IMG_DESC;
            end else begin
               return abort_file(STATUS_BAD_LABEL, rep);
            end
         end
         PS_EXT_LABEL: gif_state = (b == LABEL_GCE) ? PS_GCE_SIZE : PS_EXT_SUB;
         PS_GCE_SIZE: begin
            if (b < GCE_MIN_SIZE) return abort_file(STATUS_SHORT_GCE, rep);
            skip_left = SKIP_WIDTH'(b - GCE_FIELDS);
            field_pos = '0;
            gif_state = PS_GCE_BODY;
         end
         PS_GCE_BODY: begin
            if (field_pos == 0) begin
               field_pos = 1;
            end else if (field_pos == 1) begin
               delay_low = b;
               field_pos = 2;
            end else begin
               delay       = {b, delay_low};
               frame_delay = (delay < delay_floor_reg) ? DUR_WIDTH'(delay_fallback_reg)
                                                       : delay;
               gif_state   = PS_SKIP_EXT;
            end
         end
         PS_SKIP_EXT: begin
            skip_left--;
            if (skip_left == 0) gif_state = PS_EXT_SUB;
         end
         PS_EXT_SUB: begin
            if (b == 8'h00) begin
               gif_state = PS_LABEL;
            end else begin
               skip_left = SKIP_WIDTH'(b);
               gif_state = PS_SKIP_EXT;
            end
         end
         PS_IMG_DESC: begin
            if (field_pos < DESC_FLAGS) begin
               field_pos++;
            end else if (b[7]) begin
               skip_left = color_table_bytes(b);
               gif_state = PS_SKIP_LCT;
            end else begin
               gif_state = PS_LZW;
            end
         end
         PS_SKIP_LCT: begin
            skip_left--;
            if (skip_left == 0) gif_state = PS_LZW;
         end
         PS_LZW: begin
            if (b == 8'h00) return abort_file(STATUS_ZERO_LZW, rep);
            gif_state = PS_IMG_SUB;
         end
         PS_IMG_SUB: begin
            if (b != 8'h00) begin
               skip_left = SKIP_WIDTH'(b);
               gif_state = PS_SKIP_IMG;
            end else begin
               rep.status       = STATUS_FRAME;
               rep.keyframe     = !frame_seen;
               rep.frame_offset = packet_base;
               rep.frame_length = byte_pos - packet_base;
               rep.pts          = pts_total;
               rep.duration     = frame_delay;
               pts_total   = (PTS_MAX - pts_total < frame_delay) ? PTS_MAX
                                                                 : pts_total + frame_delay;
               frame_delay = DUR_WIDTH'(delay_fallback_reg);
               frame_seen  = 1'b1;
               packet_base = byte_pos;
               gif_state   = PS_LABEL;
               return 1'b1;
            end
         end
         PS_SKIP_IMG: begin
            skip_left--;
            if (skip_left == 0) gif_state = PS_IMG_SUB;
         end
         default: gif_state = PS_IDLE;
      endcase
      return 1'b0;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want, got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type report;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (parser_reports.size() == 0) begin
               $error("response with no pending report, status %0d", rsp_data.status);
               error_count++;
            end else begin
               want = parser_reports.pop_front();
               check_field("status", want.status, rsp_data.status);
               check_field("keyframe", want.keyframe, rsp_data.keyframe);
               check_field("frame_offset", want.frame_offset, rsp_data.frame_offset);
               check_field("frame_length", want.frame_length, rsp_data.frame_length);
               check_field("pts", want.pts, rsp_data.pts);
               check_field("duration", want.duration, rsp_data.duration);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_data.start_of_file || gif_state != PS_IDLE) parsed_count++;
            if (parse_gif_byte(req_data, report)) parser_reports.push_back(report);
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_DELAY_FLOOR) delay_floor_reg = csr_data;
            else if (csr_index == CSR_DELAY_FALLBACK) delay_fallback_reg = csr_data;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         begin
            quiet_cycles = 0;
         end else if (++quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // stream building
   function automatic void put(input logic [7:0] b, input bit sof = 1'b0);
      req_type r;
      r.data_byte     = b;
      r.start_of_file = sof;
      r.end_of_data   = 1'b0;
      file_bytes.push_back(r);
   endfunction

   function automatic void put_end(input bit sof = 1'b0);
      put(8'($urandom), sof);
      file_bytes[$].end_of_data = 1'b1;
   endfunction

   function automatic void put_sub_blocks(input int count, input int longest);
      int len;
      repeat (count) begin
         len = $urandom_range(1, longest);
         put(8'(len));
         repeat (len) put(8'($urandom));
      end
      put(8'h00);
   endfunction

   function automatic void put_header(input bit v89, input bit gct, input logic [2:0] order);
      logic [47:0] sig;
      sig = v89 ? SIG89 : SIG87;
      for (int i = 0; i < 6; i++) put(sig[47 - 8*i -: 8], i == 0);
      repeat (4) put(8'($urandom));
      put({gct, 4'($urandom), order});
      repeat (2) put(8'($urandom));
      if (gct) repeat (3 << (int'(order) + 1)) put(8'($urandom));
   endfunction

   function automatic void put_gce(input logic [7:0] size, input logic [15:0] delay);
      put(LABEL_EXTENSION);
      put(LABEL_GCE);
      put(size);
      if (size < GCE_MIN_SIZE) return;
      put(8'($urandom));
      put(delay[7:0]);
      put(delay[15:8]);
      repeat (int'(size) - 3) put(8'($urandom));
      put_sub_blocks($urandom_range(0, 1), 4);
   endfunction

   function automatic void put_other_ext();
      logic [7:0] label;
      label = 8'($urandom);
      if (label == LABEL_GCE) label = 8'hfe;
      put(LABEL_EXTENSION);
      put(label);
      put_sub_blocks($urandom_range(0, 2), 12);
   endfunction

   function automatic void put_image(input bit lct, input logic [2:0] order,
                                     input logic [7:0] lzw, input int blocks, input int longest);
      put(LABEL_IMAGE);
      repeat (8) put(8'($urandom));
      put({lct, 4'($urandom), order});
      if (lct) repeat (3 << (int'(order) + 1)) put(8'($urandom));
      put(lzw);
      if (lzw != 8'h00) put_sub_blocks(blocks, longest);
   endfunction

   function automatic logic [2:0] table_order();
      return ($urandom_range(99) < 5) ? 3'd7 : 3'($urandom_range(0, 2));
   endfunction

   function automatic logic [CFG_WIDTH-1:0] pick_delay_reg();
      case ($urandom_range(3))
         0:       return '0;
         1:       return CFG_WIDTH'(6000);
         2:       return CFG_WIDTH'($urandom_range(0, 20));
         default: return CFG_WIDTH'($urandom_range(0, 6000));
      endcase
   endfunction

   // channel drivers
   task automatic send_request(input req_type r);
      if (!steady && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         req_data  <= req_type'(10'($urandom));
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_stream();
      while (file_bytes.size() != 0) send_request(file_bytes.pop_front());
   endtask

   task automatic wait_reports_done();
      req_valid <= 1'b0;
      while (parser_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CFG_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_delays(input logic [CFG_WIDTH-1:0] floor_value, fallback_value);
      wait_reports_done();
      write_register(CSR_DELAY_FLOOR, floor_value);
      write_register(CSR_DELAY_FALLBACK, fallback_value);
      csr_valid <= 1'b0;
   endtask

   // tests
   task automatic test_file_endings();
      put_end();                            // end of data before any byte, straight from reset
      put_end(1'b1);                        // new file that is empty
      put_header(1'b0, 1'b1, 3'd0);
      put_end();                            // end of data between blocks
      put(8'h47, 1'b1);
      put(8'h49);
      put_end();                            // cut inside the signature
      put_header(1'b1, 1'b0, 3'd0);
      put(LABEL_IMAGE);
      put(8'h01);
      put(8'h02);
      put_end();                            // cut inside a descriptor
      send_stream();
   endtask

   task automatic test_frame_sequence();
      put_header(1'b1, 1'b0, 3'd0);
      put_gce(8'd4, 16'hffff);
      put_image(1'b0, 3'd0, 8'd2, 1, 3);
      put_other_ext();
      put_gce(8'd4, 16'd1);                 // below the minimum, falls back to default
      put_image(1'b1, 3'd0, 8'hff, 2, 4);
      put_image(1'b0, 3'd0, 8'd1, 0, 1);
      put(8'hff);
      file_bytes[$].data_byte = LABEL_TRAILER;
      put(8'h00);                           // ignored after the trailer
      put_end();
      send_stream();
   endtask

   task automatic test_error_codes();
      put(8'h47, 1'b1);
      put(8'h49);
      put(8'h46);
      put(8'h38);
      put(8'h38);                           // neither signature
      put(8'h61);
      put_end();
      put_header(1'b1, 1'b0, 3'd0);
      put(8'h00);                           // unknown label
      put_header(1'b0, 1'b0, 3'd0);
      put_gce(8'd3, 16'd0);                 // control extension too short
      put_header(1'b1, 1'b0, 3'd0);
      put_image(1'b0, 3'd0, 8'd0, 0, 1);    // zero LZW code size
      put(8'hff, 1'b1);                     // bad first signature byte
      send_stream();
   endtask

   task automatic test_delay_limits();
      set_delays(CFG_WIDTH'(6000), '0);
      put_header(1'b1, 1'b0, 3'd0);
      put_gce(8'd4, 16'd5999);
      put_image(1'b0, 3'd0, 8'd2, 1, 2);
      put_gce(8'd4, 16'd6000);
      put_image(1'b0, 3'd0, 8'd2, 1, 2);
      put_image(1'b0, 3'd0, 8'd2, 1, 2);
      put(LABEL_TRAILER);
      send_stream();
      set_delays('0, CFG_WIDTH'(6000));
      put_header(1'b0, 1'b0, 3'd0);
      put_gce(8'd4, 16'd0);
      put_image(1'b0, 3'd0, 8'd2, 1, 2);
      put_image(1'b0, 3'd0, 8'd2, 1, 2);
      put(LABEL_TRAILER);
      send_stream();
      set_delays(DELAY_FLOOR_RESET, DELAY_FALLBACK_RESET);
   endtask

   task automatic test_random_files();
      int          goal;
      int          cut;
      int          pick;
      logic [15:0] delay;
      logic [7:0]  gce_len;
      goal   = parsed_count + RANDOM_ITEMS;
      steady = 1'b1;
      while (parsed_count < goal) begin
         if (steady && parsed_count > goal - RANDOM_ITEMS + 300) begin
            steady = 1'b0;
            wait_reports_done();
         end
         if ($urandom_range(99) < 12) set_delays(pick_delay_reg(), pick_delay_reg());
         put_header($urandom_range(1), $urandom_range(99) < 40, table_order());
         repeat ($urandom_range(1, 4)) begin
            repeat ($urandom_range(0, 2)) begin
               if ($urandom_range(1)) begin
                  case ($urandom_range(4))
                     0:       delay = 16'(delay_floor_reg) - 16'd1;
                     1:       delay = 16'(delay_floor_reg);
                     2:       delay = 16'($urandom_range(0, 6000));
                     3:       delay = 16'($urandom);
                     default: delay = 16'($urandom_range(0, 15));
                  endcase
                  gce_len = ($urandom_range(99) < 90) ? 8'd4 : 8'($urandom);
                  put_gce(gce_len, delay);
               end else begin
                  put_other_ext();
               end
            end
            put_image($urandom_range(99) < 20, table_order(),
                      ($urandom_range(99) < 3) ? 8'h00 : 8'($urandom_range(1, 255)),
                      $urandom_range(0, 3), ($urandom_range(99) < 3) ? 255 : 10);
         end
         pick = $urandom_range(99);
         if (pick < 65) put(LABEL_TRAILER);
         else if (pick < 80) put_end();
         // broken files
         if ($urandom_range(99) < 20) begin
            cut = $urandom_range(1, file_bytes.size() - 1);
            case ($urandom_range(2))
               0: file_bytes[cut].data_byte = 8'($urandom);
               1: begin
                  file_bytes = file_bytes[0:cut-1];
                  put_end();
               end
               default: file_bytes[cut].start_of_file = 1'b1;
            endcase
         end
         if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(1, 6)) begin
               put(8'($urandom), $urandom_range(99) < 10);
               if ($urandom_range(99) < 15) file_bytes[$].end_of_data = 1'b1;
            end
         end
         send_stream();
      end
   endtask

   initial begin
      restart_file();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_file_endings();
      test_frame_sequence();
      test_error_codes();
      test_delay_limits();
      test_random_files();
      wait_reports_done();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### gif_frame_boundary_parser_core.f
hw/rtl/gfbp_pkg.sv
hw/rtl/gif_frame_boundary_parser_core.sv
bench/tb_gif_frame_boundary_parser_core.sv
